// File: rtl/core/sha256_byte_stream_hasher_top_defines.svh
// assertion macros for the sha-256 byte stream hasher
// needs clk and arst_n in the scope where a macro is used
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define SHS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shs assertion failed: same-cycle check");

// next-cycle implication, held off during reset
`define SHS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shs assertion failed: next-cycle check");

`endif

// File: rtl/core/shs_pkg.sv
// shared types, constants and round functions for the sha-256 hasher
// no dependencies
package shs_pkg;

	localparam int WORD_W     = 32;
	localparam int BUF_WORDS  = 16;
	localparam int HASH_WORDS = 8;
	localparam int ROUNDS     = 64;

	typedef logic [WORD_W-1:0] word_t;

	// message channel commands
	typedef enum logic {
		CMD_DATA   = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_LOAD,
		ST_ROUND,
		ST_UPD,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	// controls from the sequencer to the round datapath
	typedef struct packed {
		logic       load_w;
		logic       load_v;
		logic       rnd;
		logic       shift_v;
		logic [5:0] t;
	} rnd_ctrl_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] FILL_TOP = 6'd63;

	localparam word_t IV_TAB [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t K_TAB [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// big sigma 0: rotr 2, 13, 22
	function automatic word_t bsig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	// big sigma 1: rotr 6, 11, 25
	function automatic word_t bsig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	// small sigma 0: rotr 7, 18, shr 3
	function automatic word_t ssig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	// small sigma 1: rotr 17, 19, shr 10
	function automatic word_t ssig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// File: rtl/core/shs_in_if.sv
// message channel: one byte or a finish command per item
// no dependencies
interface shs_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] data_byte;

	modport source(output valid, command, data_byte, input ready);
	modport sink(input valid, command, data_byte, output ready);
endinterface

// File: rtl/core/shs_out_if.sv
// digest channel: one 32-bit digest word per item
// no dependencies
interface shs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last;

	modport source(output valid, digest_word, word_index, last, input ready);
	modport sink(input valid, digest_word, word_index, last, output ready);
endinterface

// File: rtl/core/shs_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module shs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/shs_round.sv
// compression datapath: 16-word schedule window and eight working words
// depends on shs_pkg
module shs_round (
	input  logic              clk,
	input  shs_pkg::rnd_ctrl_t ctrl,
	input  shs_pkg::word_t    buf_word,
	input  shs_pkg::word_t    hash_word,
	output shs_pkg::word_t    v0
);

	shs_pkg::word_t w_q [shs_pkg::BUF_WORDS];
	shs_pkg::word_t v_q [shs_pkg::HASH_WORDS];

	shs_pkg::word_t t1, t2, ch, maj, w_next;

	// round function on the current working words
	always_comb begin
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + shs_pkg::bsig1(v_q[4]) + ch + shs_pkg::K_TAB[ctrl.t] + w_q[0];
		t2  = shs_pkg::bsig0(v_q[0]) + maj;
		// schedule word sixteen ahead of the one in use
		w_next = shs_pkg::ssig1(w_q[14]) + w_q[9] + shs_pkg::ssig0(w_q[1]) + w_q[0];
	end

	// schedule window: filled from the buffer, then extended each round
	always_ff @(posedge clk) begin
		if (ctrl.load_w || ctrl.rnd) begin
			for (int i = 0; i < shs_pkg::BUF_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[shs_pkg::BUF_WORDS-1] <= ctrl.load_w ? buf_word : w_next;
		end
	end

	// working words: loaded from hash memory, rounds, drained for update
	always_ff @(posedge clk) begin
		if (ctrl.rnd) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end else if (ctrl.load_v || ctrl.shift_v) begin
			for (int i = 0; i < shs_pkg::HASH_WORDS - 1; i++) begin
				v_q[i] <= v_q[i+1];
			end
			v_q[shs_pkg::HASH_WORDS-1] <= hash_word;
		end
	end

	assign v0 = v_q[0];

endmodule

// File: rtl/core/sha256_byte_stream_hasher_top.sv
// channel  | dir | payload                              | accepted when
// msg      | in  | command, data_byte                   | msg.valid && msg.ready
// digest   | out | digest_word, word_index, last        | digest.valid && digest.ready
//
// the 64th data byte of a block starts a compression (load, 64 rounds, hash update)
// on the single round unit; a finish pads one byte per cycle up to the length
// field, pausing while a full block compresses, runs one or two compressions,
// then emits eight words through the hash memory
// msg.ready is high only while idle; a held digest word does not block a new byte
// reset is asynchronous; hash words read as the initial values through per-word
// valid bits, so no clearing pass follows reset
// top level of the sha-256 byte stream hasher
// depends on shs_pkg, shs_in_if, shs_out_if, shs_ram, shs_round and the defines header
`include "sha256_byte_stream_hasher_top_defines.svh"

module sha256_byte_stream_hasher_top (
	input  logic          clk,
	input  logic          arst_n,
	shs_in_if.sink        msg,
	shs_out_if.source     digest
);

	shs_pkg::state_t    state_q, state_d, ret_q, ret_d;
	logic [5:0]         cnt_q;
	logic [5:0]         fill_q;
	logic [23:0]        acc_q;
	logic [63:0]        bits_q;
	logic [60:0]        byte_cnt_q;
	logic [2:0]         emit_cnt_q;
	logic [7:0]         hvalid_q;
	logic [2:0]         hrd_addr_s1;
	logic               hvalid_s1;
	shs_pkg::word_t     dword_q;
	logic [2:0]         didx_q;
	logic               dvalid_q;

	logic               in_rdy, in_fire;
	logic               is_finish;
	logic               ins;
	logic [7:0]         ins_byte;
	logic               buf_we, buf_re;
	logic [3:0]         buf_raddr;
	shs_pkg::word_t     buf_rdata;
	logic               hash_we, hash_re;
	logic [2:0]         hash_waddr, hash_raddr;
	shs_pkg::word_t     hash_wdata, hash_rdata, hash_val, v0;
	logic               out_load;
	logic               out_free;
	logic               last_out;
	shs_pkg::rnd_ctrl_t rctrl;

	assign in_fire   = msg.valid && in_rdy;
	assign is_finish = (msg.command == shs_pkg::CMD_FINISH);
	assign out_free  = !dvalid_q || digest.ready;
	assign last_out  = out_load && (emit_cnt_q == 3'd7);

	// hash word as read: initial value until the entry is written
	assign hash_val = hvalid_s1 ? hash_rdata : shs_pkg::IV_TAB[hrd_addr_s1];

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			shs_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (is_finish) begin
						state_d = shs_pkg::ST_PAD_MARK;
					end else if (fill_q == shs_pkg::FILL_TOP) begin
						state_d = shs_pkg::ST_LOAD;
						ret_d   = shs_pkg::ST_IDLE;
					end
				end
			end
			shs_pkg::ST_PAD_MARK: begin
				if (fill_q == shs_pkg::FILL_TOP) begin
					state_d = shs_pkg::ST_LOAD;
					ret_d   = shs_pkg::ST_PAD_ZERO;
				end else begin
					state_d = shs_pkg::ST_PAD_ZERO;
				end
			end
			shs_pkg::ST_PAD_ZERO: begin
				if (fill_q == shs_pkg::LEN_POS) begin
					state_d = shs_pkg::ST_PAD_LEN;
				end else if (fill_q == shs_pkg::FILL_TOP) begin
					state_d = shs_pkg::ST_LOAD;
					ret_d   = shs_pkg::ST_PAD_ZERO;
				end
			end
			shs_pkg::ST_PAD_LEN: begin
				if (fill_q == shs_pkg::FILL_TOP) begin
					state_d = shs_pkg::ST_LOAD;
					ret_d   = shs_pkg::ST_EMIT_RD;
				end
			end
			shs_pkg::ST_LOAD: begin
				if (cnt_q == 6'd16) begin
					state_d = shs_pkg::ST_ROUND;
				end
			end
			shs_pkg::ST_ROUND: begin
				if (cnt_q == 6'd63) begin
					state_d = shs_pkg::ST_UPD;
				end
			end
			shs_pkg::ST_UPD: begin
				if (cnt_q == 6'd8) begin
					state_d = ret_q;
				end
			end
			shs_pkg::ST_EMIT_RD: begin
				if (out_free) begin
					state_d = shs_pkg::ST_EMIT_LD;
				end
			end
			shs_pkg::ST_EMIT_LD: begin
				state_d = (emit_cnt_q == 3'd7) ? shs_pkg::ST_IDLE : shs_pkg::ST_EMIT_RD;
			end
			default: begin
				state_d = shs_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_rdy       = 1'b0;
		ins          = 1'b0;
		ins_byte     = '0;
		buf_re       = 1'b0;
		buf_raddr    = cnt_q[3:0];
		hash_re      = 1'b0;
		hash_raddr   = cnt_q[2:0];
		hash_we      = 1'b0;
		hash_waddr   = cnt_q[2:0] - 3'd1;
		hash_wdata   = hash_val + v0;
		out_load     = 1'b0;
		rctrl        = '0;
		rctrl.t      = cnt_q;
		unique case (state_q)
			shs_pkg::ST_IDLE: begin
				in_rdy   = 1'b1;
				ins      = in_fire && !is_finish;
				ins_byte = msg.data_byte;
			end
			shs_pkg::ST_PAD_MARK: begin
				ins      = 1'b1;
				ins_byte = shs_pkg::PAD_BYTE;
			end
			shs_pkg::ST_PAD_ZERO: begin
				ins = (fill_q != shs_pkg::LEN_POS);
			end
			shs_pkg::ST_PAD_LEN: begin
				ins      = 1'b1;
				ins_byte = bits_q[63:56];
			end
			shs_pkg::ST_LOAD: begin
				buf_re       = (cnt_q < 6'd16);
				hash_re      = (cnt_q < 6'd8);
				rctrl.load_w = (cnt_q != 6'd0);
				rctrl.load_v = (cnt_q != 6'd0) && (cnt_q <= 6'd8);
			end
			shs_pkg::ST_ROUND: begin
				rctrl.rnd = 1'b1;
			end
			shs_pkg::ST_UPD: begin
				hash_re       = (cnt_q < 6'd8);
				hash_we       = (cnt_q != 6'd0);
				rctrl.shift_v = (cnt_q != 6'd0);
			end
			shs_pkg::ST_EMIT_RD: begin
				hash_re    = out_free;
				hash_raddr = emit_cnt_q;
			end
			shs_pkg::ST_EMIT_LD: begin
				out_load = 1'b1;
			end
			default: begin
				in_rdy = 1'b0;
			end
		endcase
	end

	// a full word of bytes goes to the buffer memory
	assign buf_we = ins && (fill_q[1:0] == 2'b11);

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shs_pkg::ST_IDLE;
			ret_q   <= shs_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			cnt_q   <= (state_d != state_q) ? 6'd0 : cnt_q + 6'd1;
		end
	end

	// message position, length and hash valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			byte_cnt_q <= '0;
			emit_cnt_q <= '0;
			hvalid_q   <= '0;
		end else begin
			if (ins) begin
				fill_q <= fill_q + 6'd1;
			end
			if (in_fire && !is_finish) begin
				byte_cnt_q <= byte_cnt_q + 61'd1;
			end
			if (hash_we) begin
				hvalid_q[hash_waddr] <= 1'b1;
			end
			if (out_load) begin
				emit_cnt_q <= emit_cnt_q + 3'd1;
				// last word out: start the next message
				if (emit_cnt_q == 3'd7) begin
					fill_q     <= '0;
					byte_cnt_q <= '0;
					hvalid_q   <= '0;
				end
			end
		end
	end

	// byte packing and length shifter
	always_ff @(posedge clk) begin
		if (ins) begin
			acc_q <= {acc_q[15:0], ins_byte};
		end
		if (in_fire && is_finish) begin
			bits_q <= {byte_cnt_q, 3'b000};
		end else if (state_q == shs_pkg::ST_PAD_LEN) begin
			bits_q <= {bits_q[55:0], 8'h00};
		end
	end

	// hash read tag, follows the memory read latency
	always_ff @(posedge clk) begin
		if (hash_re) begin
			hrd_addr_s1 <= hash_raddr;
			hvalid_s1   <= hvalid_q[hash_raddr];
		end
	end

	// digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_q <= 1'b0;
		end else if (out_load) begin
			dvalid_q <= 1'b1;
		end else if (digest.ready) begin
			dvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dword_q <= hash_val;
			didx_q  <= emit_cnt_q;
		end
	end

	assign msg.ready          = in_rdy;
	assign digest.valid       = dvalid_q;
	assign digest.digest_word = dword_q;
	assign digest.word_index  = didx_q;
	assign digest.last        = (didx_q == 3'd7);

	// block buffer, one word per four bytes
	shs_ram #(
		.WIDTH(shs_pkg::WORD_W),
		.DEPTH(shs_pkg::BUF_WORDS)
	) u_buf_ram (
		.clk  (clk),
		.we   (buf_we),
		.waddr(fill_q[5:2]),
		.wdata({acc_q, ins_byte}),
		.re   (buf_re),
		.raddr(buf_raddr),
		.rdata(buf_rdata)
	);

	// hash words
	shs_ram #(
		.WIDTH(shs_pkg::WORD_W),
		.DEPTH(shs_pkg::HASH_WORDS)
	) u_hash_ram (
		.clk  (clk),
		.we   (hash_we),
		.waddr(hash_waddr),
		.wdata(hash_wdata),
		.re   (hash_re),
		.raddr(hash_raddr),
		.rdata(hash_rdata)
	);

	// round datapath
	shs_round u_round (
		.clk      (clk),
		.ctrl     (rctrl),
		.buf_word (buf_rdata),
		.hash_word(hash_val),
		.v0       (v0)
	);

	// compression only starts on a full block
	`SHS_ASSERT_IMPL(a_load_full, state_q == shs_pkg::ST_LOAD, fill_q == 6'd0)
	// update never writes the hash entry it reads in the same cycle
	`SHS_ASSERT_IMPL(a_hash_rw, hash_we && hash_re, hash_waddr != hash_raddr)
	// a digest word is loaded only into an empty output register
	`SHS_ASSERT_IMPL(a_out_empty, out_load, !dvalid_q)
	// after the last word the message state is back at its start
	`SHS_ASSERT_NEXT(a_restart, last_out, fill_q == 6'd0 && byte_cnt_q == 61'd0 && hvalid_q == 8'd0)

endmodule
